// File: rtl/crga_pkg.sv
// crga_pkg: shared types and constants for the column residual gain argmin block
// command and status structs between controller and datapath, square step codes
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package crga_pkg;

  // column counter wraps after this many candidates
  localparam int unsigned MaxCols = 256;

  // accumulator and divider widths
  localparam int unsigned AccW  = 42;
  localparam int unsigned HalfW = 21;
  localparam int unsigned SqW   = 84;
  localparam int unsigned DivW  = 48;
  localparam int unsigned RhoW  = 32;
  localparam int unsigned ColW  = 8;

  // partial product select for the split square of the dot magnitude
  typedef enum logic [1:0] {
    PP_LL = 2'd0,
    PP_HL = 2'd1,
    PP_HH = 2'd2
  } pp_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic    in_fire;
    logic    start;
    logic    mul_en;
    pp_sel_e mul_sel;
    logic    add_en;
    pp_sel_e add_sel;
    logic    div_init;
    logic    div_step;
    logic    rho_en;
    logic    fin;
  } crga_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic s_zero;
    logic out_busy;
  } crga_stat_t;

endpackage

`default_nettype wire

// File: rtl/column_residual_gain_argmin.sv
// column_residual_gain_argmin: top level, joins sequencer and datapath
// depends on: crga_pkg, crga_ctrl, crga_dp
// throughput: one element per cycle within a column; after a column's last element the input
// stalls through the square, divide and result phases, longer while a finished result is still held
// result order: square, divide, rho, output register; a zero-norm column skips square and divide
// reset: async, clears accumulators, column count and best index, best rho to all ones
`timescale 1ns / 1ps
`default_nettype none

module column_residual_gain_argmin (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] col_element_i,
  input  wire logic signed [15:0] residual_element_i,
  input  wire logic [15:0]        res_norm_i,
  input  wire logic               last_row_i,
  input  wire logic               last_column_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             rho_o,
  output logic [7:0]              column_index_o,
  output logic [7:0]              best_index_o,
  output logic                    final_res_o
);
  import crga_pkg::*;

  crga_cmd_t  cmd;
  crga_stat_t stat;

  // phase sequencer
  crga_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_last_row_i (last_row_i),
    .in_stall_o    (in_stall_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // arithmetic and result register
  crga_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .col_element_i      (col_element_i),
    .residual_element_i (residual_element_i),
    .res_norm_i         (res_norm_i),
    .last_column_i      (last_column_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .rho_o              (rho_o),
    .column_index_o     (column_index_o),
    .best_index_o       (best_index_o),
    .final_res_o        (final_res_o)
  );

endmodule

`default_nettype wire

// File: rtl/crga_ctrl.sv
// crga_ctrl: sequencer for accumulate, square, divide and result phases
// depends on: crga_pkg
`timescale 1ns / 1ps
`default_nettype none

module crga_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_last_row_i,
  output logic                        in_stall_o,
  input  wire crga_pkg::crga_stat_t   stat_i,
  output crga_pkg::crga_cmd_t         cmd_o
);
  import crga_pkg::*;

  localparam logic [3:0] StAcc   = 4'd0;
  localparam logic [3:0] StFlush = 4'd1;
  localparam logic [3:0] StStart = 4'd2;
  localparam logic [3:0] StM0    = 4'd3;
  localparam logic [3:0] StM1    = 4'd4;
  localparam logic [3:0] StM2    = 4'd5;
  localparam logic [3:0] StM3    = 4'd6;
  localparam logic [3:0] StDchk  = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StRho   = 4'd9;
  localparam logic [3:0] StFin   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       in_fire;

  // input is taken only while accumulating a column
  assign in_stall_o = (state_q != StAcc);
  assign in_fire    = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.mul_sel = PP_LL;
    cmd_o.add_sel = PP_LL;
    cmd_o.in_fire = in_fire;
    unique case (state_q)
      StAcc: begin
        if (in_fire && in_last_row_i) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        state_d = StStart;
      end
      StStart: begin
        cmd_o.start = 1'b1;
        state_d     = stat_i.s_zero ? StRho : StM0;
      end
      StM0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = PP_LL;
        state_d       = StM1;
      end
      StM1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = PP_HL;
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = PP_LL;
        state_d       = StM2;
      end
      StM2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = PP_HH;
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = PP_HL;
        state_d       = StM3;
      end
      StM3: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = PP_HH;
        state_d       = StDchk;
      end
      StDchk: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = 5'd31;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = StRho;
        end
      end
      StRho: begin
        cmd_o.rho_en = 1'b1;
        state_d      = StFin;
      end
      StFin: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = StAcc;
        end
      end
      default: begin
        state_d = StAcc;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // a column end always closes the input for the result phase
  a_last_row_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last_row_i |=> in_stall_o)
    else $error("input not stalled after column end");

  // divider runs exactly 32 steps before the rho stage
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_init |=> ##32 (state_q == StRho))
    else $error("divider step count wrong");
`endif

endmodule

`default_nettype wire

// File: rtl/crga_dp.sv
// crga_dp: multiply-accumulate, split square, bit-serial divider, argmin and output register
// depends on: crga_pkg
`timescale 1ns / 1ps
`default_nettype none

module crga_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire crga_pkg::crga_cmd_t   cmd_i,
  output crga_pkg::crga_stat_t       stat_o,
  input  wire logic signed [15:0]    col_element_i,
  input  wire logic signed [15:0]    residual_element_i,
  input  wire logic [15:0]           res_norm_i,
  input  wire logic                  last_column_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [31:0]                rho_o,
  output logic [7:0]                 column_index_o,
  output logic [7:0]                 best_index_o,
  output logic                       final_res_o
);
  import crga_pkg::*;

  localparam logic [ColW-1:0] ColLast = ColW'(MaxCols - 1);
  localparam logic [AccW-1:0] SqMax   = {AccW{1'b1}};
  localparam logic [AccW-1:0] DotMax  = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] DotMin  = {1'b1, {(AccW-1){1'b0}}};

  // product stage
  logic signed [31:0] aa_prod, ar_prod;
  logic [30:0]        pa_q;
  logic signed [31:0] pr_q;
  logic               prod_vld_q;
  logic [15:0]        n_q;
  logic               lcol_q;

  // accumulators
  logic [AccW-1:0]    sq_acc_q, sq_acc_d;
  logic [AccW-1:0]    dot_acc_q, dot_acc_d;
  logic [AccW:0]      sq_sum;
  logic signed [AccW:0] dot_sum;

  // operand latch and square
  logic [AccW-1:0]    d_abs, d_q;
  logic [DivW-1:0]    v_q;
  logic               zero_q;
  logic [RhoW-1:0]    nsq_q;
  logic [HalfW-1:0]   opa, opb;
  logic [2*HalfW-1:0] mprod_q;
  logic [SqW-1:0]     sq_q, pp_sh;

  // divider
  logic [SqW-RhoW-1:0] hi_part;
  logic [DivW-1:0]     rem_q;
  logic [RhoW-1:0]     qlo_q;
  logic                ovf_q;
  logic [DivW:0]       trial;
  logic                ge;

  // result and argmin
  logic [RhoW-1:0]    rho_q;
  logic [RhoW-1:0]    best_rho_q;
  logic [ColW-1:0]    best_col_q, best_col_new;
  logic [ColW-1:0]    cnt_q;
  logic               better;
  logic               out_valid_q;

  // element products
  assign aa_prod = col_element_i * col_element_i;
  assign ar_prod = col_element_i * residual_element_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_fire) begin
      pa_q   <= aa_prod[30:0];
      pr_q   <= ar_prod;
      n_q    <= res_norm_i;
      lcol_q <= last_column_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.in_fire;
    end
  end

  // saturating accumulate
  assign sq_sum  = {1'b0, sq_acc_q} + (AccW+1)'(pa_q);
  assign dot_sum = $signed({dot_acc_q[AccW-1], dot_acc_q}) + (AccW+1)'(pr_q);

  always_comb begin
    sq_acc_d  = sq_acc_q;
    dot_acc_d = dot_acc_q;
    if (cmd_i.start) begin
      sq_acc_d  = '0;
      dot_acc_d = '0;
    end else if (prod_vld_q) begin
      sq_acc_d = sq_sum[AccW] ? SqMax : sq_sum[AccW-1:0];
      if (dot_sum[AccW] != dot_sum[AccW-1]) begin
        dot_acc_d = dot_sum[AccW] ? DotMin : DotMax;
      end else begin
        dot_acc_d = dot_sum[AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_acc_q  <= '0;
      dot_acc_q <= '0;
    end else begin
      sq_acc_q  <= sq_acc_d;
      dot_acc_q <= dot_acc_d;
    end
  end

  // magnitude of the dot product
  assign d_abs = dot_acc_q[AccW-1] ? (~dot_acc_q + AccW'(1)) : dot_acc_q;

  // operand select for the shared half-width multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      PP_LL:   begin opa = d_q[HalfW-1:0];    opb = d_q[HalfW-1:0]; end
      PP_HL:   begin opa = d_q[AccW-1:HalfW]; opb = d_q[HalfW-1:0]; end
      PP_HH:   begin opa = d_q[AccW-1:HalfW]; opb = d_q[AccW-1:HalfW]; end
      default: begin opa = '0;                opb = '0; end
    endcase
  end

  // cross term counts twice, so it sits one bit higher
  always_comb begin
    case (cmd_i.add_sel)
      PP_LL:   pp_sh = SqW'(mprod_q);
      PP_HL:   pp_sh = SqW'(mprod_q) << (HalfW + 1);
      PP_HH:   pp_sh = SqW'(mprod_q) << (2 * HalfW);
      default: pp_sh = '0;
    endcase
  end

  // divider trial subtract
  assign hi_part = sq_q[SqW-1:RhoW];
  assign trial   = {rem_q, qlo_q[RhoW-1]};
  assign ge      = (trial >= {1'b0, v_q});

  // operand latch, square and divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      d_q    <= d_abs;
      v_q    <= {sq_acc_q, 6'b0};
      zero_q <= (sq_acc_q == '0);
      nsq_q  <= n_q * n_q;
      sq_q   <= '0;
    end
    if (cmd_i.mul_en) begin
      mprod_q <= opa * opb;
    end
    if (cmd_i.add_en) begin
      sq_q <= sq_q + pp_sh;
    end
    if (cmd_i.div_init) begin
      ovf_q <= (hi_part >= (SqW-RhoW)'(v_q));
      rem_q <= hi_part[DivW-1:0];
      qlo_q <= sq_q[RhoW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? DivW'(trial - {1'b0, v_q}) : trial[DivW-1:0];
      qlo_q <= {qlo_q[RhoW-2:0], ge};
    end
    if (cmd_i.rho_en) begin
      if (zero_q) begin
        rho_q <= nsq_q;
      end else if (ovf_q || (qlo_q >= nsq_q)) begin
        rho_q <= '0;
      end else begin
        rho_q <= nsq_q - qlo_q;
      end
    end
  end

  // running argmin, first column wins ties
  assign better       = (rho_q < best_rho_q);
  assign best_col_new = better ? cnt_q : best_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      best_rho_q <= '1;
      best_col_q <= '0;
    end else if (cmd_i.fin) begin
      if (lcol_q) begin
        cnt_q      <= '0;
        best_rho_q <= '1;
        best_col_q <= '0;
      end else begin
        cnt_q      <= (cnt_q == ColLast) ? '0 : cnt_q + ColW'(1);
        best_rho_q <= better ? rho_q : best_rho_q;
        best_col_q <= best_col_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      rho_o          <= rho_q;
      column_index_o <= cnt_q;
      best_index_o   <= best_col_new;
      final_res_o    <= lcol_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign stat_o.s_zero   = (sq_acc_q == '0);

`ifndef SYNTHESIS
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled transfer");

  // best rho never exceeds the rho just folded in
  a_best_le_rho: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin && !lcol_q |=> best_rho_q <= $past(rho_q))
    else $error("argmin tracking lost a smaller rho");

  // zero-norm column passes norm squared through
  a_zero_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rho_en && zero_q |=> rho_q == $past(nsq_q))
    else $error("zero-norm column rho wrong");

  // saturated gain clamps rho to zero
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rho_en && !zero_q && ovf_q |=> rho_q == '0)
    else $error("saturated gain did not clamp rho");
`endif

endmodule

`default_nettype wire
